// ===== sv/udrb_pkg.sv =====
// ----------------------------------------------------------------------------
// udrb_pkg
// Shared constants, codes and types of the dual UART ring buffer.
// ----------------------------------------------------------------------------
package udrb_pkg;

  localparam int RX_DEPTH = 128;
  localparam int TX_DEPTH = 128;
  localparam int RX_AW    = $clog2(RX_DEPTH);
  localparam int TX_AW    = $clog2(TX_DEPTH);

  typedef logic [RX_AW-1:0] rx_ptr_t;
  typedef logic [TX_AW-1:0] tx_ptr_t;

  typedef enum logic [1:0] {
    ACT_LINE_BYTE = 2'd0,
    ACT_TX_READY  = 2'd1,
    ACT_CPU_READ  = 2'd2,
    ACT_CPU_WRITE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_RX_DROPPED = 2'd1,
    ST_READ_EMPTY = 2'd2,
    ST_WRITE_FULL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SEND_NONE   = 2'd0,
    SEND_RING   = 2'd1,
    SEND_DIRECT = 2'd2
  } send_sel_t;

  typedef struct packed {
    send_sel_t  send_sel;
    logic       rx_take;
    logic [7:0] cpu_byte;
    status_t    status;
    logic       rx_available;
    logic       tx_drained;
  } req_t;

endpackage

// ===== sv/udrb_ram.sv =====
// ----------------------------------------------------------------------------
// udrb_ram
// Simple dual-port synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module udrb_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/uart_dual_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// uart_dual_ring_buffer
// Receive and transmit byte rings between a UART and a CPU.
// ----------------------------------------------------------------------------
// One event is taken per clock cycle while in_ready is high. Pointers are
// updated in the cycle the event is accepted. The ring RAMs return data at
// that same edge. The result beat then moves from the request stage into the
// output register once that register is empty or being taken.
// Each ring holds at most depth minus one bytes. Back-pressure on the result
// channel stalls the input once the request stage and output register fill.
module uart_dual_ring_buffer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  logic [7:0] data_byte,
  input  logic       hw_tx_full,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       send_valid,
  output logic [7:0] send_byte,
  output logic [7:0] read_byte,
  output logic [1:0] status,
  output logic       rx_available,
  output logic       tx_drained
);

  udrb_pkg::rx_ptr_t rx_wptr, rx_wptr_next, rx_rptr, rx_rptr_next;
  udrb_pkg::tx_ptr_t tx_wptr, tx_wptr_next, tx_rptr, tx_rptr_next;
  udrb_pkg::req_t    req, req_next;
  logic              req_valid;
  logic              in_fire, req_adv;
  logic              rx_we, rx_re, tx_we, tx_re;
  logic [7:0]        rx_rdata, tx_rdata;
  logic              rx_empty, rx_full, tx_empty, tx_full;

  assign req_adv  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || req_adv;
  assign in_fire  = in_valid && in_ready;

  assign rx_empty = (rx_rptr == rx_wptr);
  assign rx_full  = ((rx_wptr + udrb_pkg::RX_AW'(1)) == rx_rptr);
  assign tx_empty = (tx_rptr == tx_wptr);
  assign tx_full  = ((tx_wptr + udrb_pkg::TX_AW'(1)) == tx_rptr);

  always_comb begin
    rx_wptr_next      = rx_wptr;
    rx_rptr_next      = rx_rptr;
    tx_wptr_next      = tx_wptr;
    tx_rptr_next      = tx_rptr;
    rx_we             = 1'b0;
    rx_re             = 1'b0;
    tx_we             = 1'b0;
    tx_re             = 1'b0;
    req_next.send_sel = udrb_pkg::SEND_NONE;
    req_next.rx_take  = 1'b0;
    req_next.cpu_byte = data_byte;
    req_next.status   = udrb_pkg::ST_OK;
    case (udrb_pkg::action_t'(action))
      udrb_pkg::ACT_LINE_BYTE: begin
        if (rx_full) begin
          req_next.status = udrb_pkg::ST_RX_DROPPED;
        end else begin
          rx_we        = in_fire;
          rx_wptr_next = rx_wptr + udrb_pkg::RX_AW'(1);
        end
      end
      udrb_pkg::ACT_TX_READY: begin
        if (!tx_empty && !hw_tx_full) begin
          tx_re             = in_fire;
          tx_rptr_next      = tx_rptr + udrb_pkg::TX_AW'(1);
          req_next.send_sel = udrb_pkg::SEND_RING;
        end
      end
      udrb_pkg::ACT_CPU_READ: begin
        if (rx_empty) begin
          req_next.status = udrb_pkg::ST_READ_EMPTY;
        end else begin
          rx_re            = in_fire;
          rx_rptr_next     = rx_rptr + udrb_pkg::RX_AW'(1);
          req_next.rx_take = 1'b1;
        end
      end
      udrb_pkg::ACT_CPU_WRITE: begin
        if (tx_full) begin
          req_next.status = udrb_pkg::ST_WRITE_FULL;
        end else if (!tx_empty || hw_tx_full) begin
          tx_we        = in_fire;
          tx_wptr_next = tx_wptr + udrb_pkg::TX_AW'(1);
        end else begin
          req_next.send_sel = udrb_pkg::SEND_DIRECT;
        end
      end
      default: begin
        req_next.status = udrb_pkg::ST_OK;
      end
    endcase
    req_next.rx_available = (rx_rptr_next != rx_wptr_next);
    req_next.tx_drained   = (tx_rptr_next == tx_wptr_next);
  end

  udrb_ram #(.DEPTH(udrb_pkg::RX_DEPTH), .WIDTH(8)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_wptr),
    .wdata (data_byte),
    .re    (rx_re),
    .raddr (rx_rptr),
    .rdata (rx_rdata)
  );

  udrb_ram #(.DEPTH(udrb_pkg::TX_DEPTH), .WIDTH(8)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_wptr),
    .wdata (data_byte),
    .re    (tx_re),
    .raddr (tx_rptr),
    .rdata (tx_rdata)
  );

  // advance pointers on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_wptr <= '0;
      rx_rptr <= '0;
      tx_wptr <= '0;
      tx_rptr <= '0;
    end else if (in_fire) begin
      rx_wptr <= rx_wptr_next;
      rx_rptr <= rx_rptr_next;
      tx_wptr <= tx_wptr_next;
      tx_rptr <= tx_rptr_next;
    end
  end

  // request stage: hold while RAM data is pending
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_fire) begin
      req_valid <= 1'b1;
    end else if (req_adv) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req <= req_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_adv) begin
      send_valid   <= (req.send_sel != udrb_pkg::SEND_NONE);
      case (req.send_sel)
        udrb_pkg::SEND_RING:   send_byte <= tx_rdata;
        udrb_pkg::SEND_DIRECT: send_byte <= req.cpu_byte;
        default:               send_byte <= 8'd0;
      endcase
      read_byte    <= req.rx_take ? rx_rdata : 8'd0;
      status       <= req.status;
      rx_available <= req.rx_available;
      tx_drained   <= req.tx_drained;
    end
  end

`ifndef SYNTHESIS
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_adv |=> req_valid && $stable(req))
    else $error("request stage dropped a pending beat");

  a_send_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && send_valid |-> status == udrb_pkg::ST_OK)
    else $error("byte sent with error status");

  a_empty_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == udrb_pkg::ST_READ_EMPTY |-> read_byte == 8'd0 && !rx_available)
    else $error("empty read returned data or reported occupancy");

  a_ring_pop: assert property (@(posedge clk) disable iff (rst)
    in_fire && action == udrb_pkg::ACT_TX_READY && !hw_tx_full && !tx_empty
    |=> tx_rptr != $past(tx_rptr) && tx_wptr == $past(tx_wptr))
    else $error("transmit ring pop did not advance read pointer");
`endif

endmodule

// ===== test/udrb_ring_check.sv =====
// ----------------------------------------------------------------------------
// udrb_ring_check
// Watches both channels of the dual UART ring buffer, predicts each result
// beat from the accepted events and compares it field by field.
// ----------------------------------------------------------------------------
module udrb_ring_check (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] action,
  input  logic [7:0] data_byte,
  input  logic       hw_tx_full,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       send_valid,
  input  logic [7:0] send_byte,
  input  logic [7:0] read_byte,
  input  logic [1:0] status,
  input  logic       rx_available,
  input  logic       tx_drained,
  output int         fail_count,
  output int         outstanding
);

  typedef struct {
    logic              send_valid;
    logic [7:0]        send_byte;
    logic [7:0]        read_byte;
    udrb_pkg::status_t status;
    logic              rx_available;
    logic              tx_drained;
  } ring_result_t;

  logic [7:0]        rx_bytes [udrb_pkg::RX_DEPTH];
  logic [7:0]        tx_bytes [udrb_pkg::TX_DEPTH];
  udrb_pkg::rx_ptr_t rx_wr, rx_rd;
  udrb_pkg::tx_ptr_t tx_wr, tx_rd;
  ring_result_t      due_results [$];
  int                mismatches;

  initial begin
    mismatches = 0;
  end

  function automatic ring_result_t apply_event(udrb_pkg::action_t act,
                                               logic [7:0] data_in, logic hw_full);
    ring_result_t      r;
    udrb_pkg::rx_ptr_t rx_next;
    udrb_pkg::tx_ptr_t tx_next;
    r.send_valid = 1'b0;
    r.send_byte  = 8'h00;
    r.read_byte  = 8'h00;
    r.status     = udrb_pkg::ST_OK;
    rx_next      = rx_wr + udrb_pkg::RX_AW'(1);
    tx_next      = tx_wr + udrb_pkg::TX_AW'(1);
    case (act)
      udrb_pkg::ACT_LINE_BYTE: begin
        if (rx_next == rx_rd) begin
          r.status = udrb_pkg::ST_RX_DROPPED;
        end else begin
          rx_bytes[rx_wr] = data_in;
          rx_wr = rx_next;
        end
      end
      udrb_pkg::ACT_TX_READY: begin
        if (tx_rd != tx_wr && !hw_full) begin
          r.send_valid = 1'b1;
          r.send_byte  = tx_bytes[tx_rd];
          tx_rd = tx_rd + udrb_pkg::TX_AW'(1);
        end
      end
      udrb_pkg::ACT_CPU_READ: begin
        if (rx_rd == rx_wr) begin
          r.status = udrb_pkg::ST_READ_EMPTY;
        end else begin
          r.read_byte = rx_bytes[rx_rd];
          rx_rd = rx_rd + udrb_pkg::RX_AW'(1);
        end
      end
      default: begin
        if (tx_next == tx_rd) begin
          r.status = udrb_pkg::ST_WRITE_FULL;
        end else if (tx_rd != tx_wr || hw_full) begin
          tx_bytes[tx_wr] = data_in;
          tx_wr = tx_next;
        end else begin
          r.send_valid = 1'b1;
          r.send_byte  = data_in;
        end
      end
    endcase
    r.rx_available = (rx_rd != rx_wr);
    r.tx_drained   = (tx_rd == tx_wr);
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_val,
                                      logic [7:0] act_val);
    if (act_val !== exp_val) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val,
               act_val);
    end
  endfunction

  always @(posedge clk) begin
    ring_result_t exp_beat;
    if (rst) begin
      rx_wr = '0;
      rx_rd = '0;
      tx_wr = '0;
      tx_rd = '0;
      due_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with none expected, actual send %0h/%0h read %0h",
                   $time, send_valid, send_byte, read_byte);
        end else begin
          exp_beat = due_results.pop_front();
          check_field("send_valid", 8'(exp_beat.send_valid), 8'(send_valid));
          check_field("send_byte", exp_beat.send_byte, send_byte);
          check_field("read_byte", exp_beat.read_byte, read_byte);
          check_field("status", 8'(exp_beat.status), 8'(status));
          check_field("rx_available", 8'(exp_beat.rx_available), 8'(rx_available));
          check_field("tx_drained", 8'(exp_beat.tx_drained), 8'(tx_drained));
        end
      end
      if (in_valid && in_ready) begin
        due_results.push_back(apply_event(udrb_pkg::action_t'(action), data_byte,
                                          hw_tx_full));
      end
    end
    fail_count  <= mismatches;
    outstanding <= due_results.size();
  end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random UART and CPU events into the dual ring buffer,
// with random idling on both channels and one long receiver hold-off, and
// gives the verdict from the failure count of the ring checker.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NUM_EVENTS  = 2000;
  localparam int HOLD_START  = 1500;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  logic       hw_tx_full;
  logic       out_valid;
  logic       out_ready;
  logic       send_valid;
  logic [7:0] send_byte;
  logic [7:0] read_byte;
  logic [1:0] status;
  logic       rx_available;
  logic       tx_drained;
  int         fail_count;
  int         outstanding;
  int         stall_cycles;

  uart_dual_ring_buffer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .data_byte    (data_byte),
    .hw_tx_full   (hw_tx_full),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .send_valid   (send_valid),
    .send_byte    (send_byte),
    .read_byte    (read_byte),
    .status       (status),
    .rx_available (rx_available),
    .tx_drained   (tx_drained)
  );

  udrb_ring_check ring_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .data_byte    (data_byte),
    .hw_tx_full   (hw_tx_full),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .send_valid   (send_valid),
    .send_byte    (send_byte),
    .read_byte    (read_byte),
    .status       (status),
    .rx_available (rx_available),
    .tx_drained   (tx_drained),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one event beat, possibly after an idle gap, and hold it until taken.
  task automatic offer_event(udrb_pkg::action_t act, logic [7:0] data, logic full,
                             bit may_idle);
    int gap;
    @(negedge clk);
    if (may_idle && $urandom_range(99) < 15) begin
      gap = $urandom_range(1, 6);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    action     = act;
    data_byte  = data;
    hw_tx_full = full;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Receiver: random stalls, a quiet window, and one long hold-off.
  initial begin
    int unsigned rx_cycle;
    rx_cycle  = 0;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES)
        out_ready = 1'b0;
      else if (rx_cycle >= 600 && rx_cycle < 1100)
        out_ready = 1'b1;
      else
        out_ready = ($urandom_range(99) >= 15);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    udrb_pkg::action_t act;
    udrb_pkg::action_t mode;
    logic [7:0]        data;
    logic              full;
    bit                may_idle;
    rst          = 1'b1;
    in_valid     = 1'b0;
    action       = udrb_pkg::ACT_LINE_BYTE;
    data_byte    = 8'h00;
    hw_tx_full   = 1'b0;
    mode         = udrb_pkg::ACT_LINE_BYTE;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    offer_event(udrb_pkg::ACT_CPU_READ,  8'h00, 1'b0, 1'b1);
    offer_event(udrb_pkg::ACT_TX_READY,  8'h00, 1'b0, 1'b1);
    offer_event(udrb_pkg::ACT_CPU_WRITE, 8'hFF, 1'b0, 1'b1);
    offer_event(udrb_pkg::ACT_CPU_WRITE, 8'h00, 1'b1, 1'b1);
    offer_event(udrb_pkg::ACT_CPU_WRITE, 8'hA5, 1'b0, 1'b1);
    offer_event(udrb_pkg::ACT_TX_READY,  8'hFF, 1'b1, 1'b1);
    offer_event(udrb_pkg::ACT_TX_READY,  8'h00, 1'b0, 1'b1);
    offer_event(udrb_pkg::ACT_TX_READY,  8'h5A, 1'b0, 1'b1);
    offer_event(udrb_pkg::ACT_TX_READY,  8'h00, 1'b0, 1'b1);
    offer_event(udrb_pkg::ACT_LINE_BYTE, 8'h00, 1'b0, 1'b1);
    offer_event(udrb_pkg::ACT_LINE_BYTE, 8'hFF, 1'b1, 1'b1);
    offer_event(udrb_pkg::ACT_LINE_BYTE, 8'h5A, 1'b0, 1'b1);
    offer_event(udrb_pkg::ACT_CPU_READ,  8'hFF, 1'b1, 1'b1);
    offer_event(udrb_pkg::ACT_CPU_READ,  8'h00, 1'b0, 1'b1);
    offer_event(udrb_pkg::ACT_CPU_READ,  8'h00, 1'b0, 1'b1);
    offer_event(udrb_pkg::ACT_CPU_READ,  8'h00, 1'b0, 1'b1);

    // Phases favor one action so the rings fill to full and drain to empty.
    for (int i = 0; i < NUM_EVENTS; i++) begin
      if (i % 200 == 0)
        mode = udrb_pkg::action_t'($urandom_range(3));
      if ($urandom_range(99) < 80)
        act = mode;
      else
        act = udrb_pkg::action_t'($urandom_range(3));
      data = 8'($urandom_range(255));
      case (mode)
        udrb_pkg::ACT_CPU_WRITE: full = ($urandom_range(99) < 85);
        udrb_pkg::ACT_TX_READY:  full = ($urandom_range(99) < 15);
        default:                 full = 1'($urandom_range(1));
      endcase
      may_idle = !(i >= 400 && i < 700);
      offer_event(act, data, full, may_idle);
    end
    @(negedge clk);
    in_valid = 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
